FILE: sv/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg
// Shared types, constants and helpers for the p-code stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsm_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int AW = $clog2(STACK_DEPTH);
  // signed working width for index arithmetic (index plus 16-bit offset)
  localparam int EW = AW + 18;

  localparam logic [AW-1:0] LAST_IDX = AW'(STACK_DEPTH - 1);
  localparam logic signed [EW-1:0] DEPTH_E = EW'(STACK_DEPTH);
  localparam logic [32:0] DEPTH_33 = 33'(STACK_DEPTH);
  localparam logic signed [EW-1:0] E1 = EW'(1);
  localparam logic signed [EW-1:0] E2 = EW'(2);
  localparam logic signed [EW-1:0] LINK_WORDS = EW'(3);

  // opcodes
  localparam logic [3:0] OP_LIT = 4'd0;
  localparam logic [3:0] OP_OPR = 4'd1;
  localparam logic [3:0] OP_LOD = 4'd2;
  localparam logic [3:0] OP_STO = 4'd3;
  localparam logic [3:0] OP_CAL = 4'd4;
  localparam logic [3:0] OP_INI = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_JNE = 4'd7;
  localparam logic [3:0] OP_JEQ = 4'd8;
  localparam logic [3:0] OP_IN  = 4'd9;
  localparam logic [3:0] OP_OUT = 4'd10;

  // opr sub-operations
  localparam logic [15:0] OPR_RET  = 16'd0;
  localparam logic [15:0] OPR_NEG  = 16'd1;
  localparam logic [15:0] OPR_ADD  = 16'd2;
  localparam logic [15:0] OPR_SUB  = 16'd3;
  localparam logic [15:0] OPR_MUL  = 16'd4;
  localparam logic [15:0] OPR_DIV  = 16'd5;
  localparam logic [15:0] OPR_ODD  = 16'd6;
  localparam logic [15:0] OPR_EQ   = 16'd7;
  localparam logic [15:0] OPR_LT   = 16'd8;
  localparam logic [15:0] OPR_GT   = 16'd9;
  localparam logic [15:0] OPR_AND  = 16'd10;
  localparam logic [15:0] OPR_OR   = 16'd11;
  localparam logic [15:0] OPR_NOT  = 16'd12;
  localparam logic [15:0] OPR_XOR  = 16'd13;
  localparam logic [15:0] OPR_LAND = 16'd14;
  localparam logic [15:0] OPR_LOR  = 16'd15;
  localparam logic [15:0] OPR_SHF  = 16'd16;

  // fault codes
  localparam logic [1:0] F_NONE  = 2'd0;
  localparam logic [1:0] F_DIV0  = 2'd1;
  localparam logic [1:0] F_RANGE = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_WALK_RD, S_LINK, S_LOD, S_STO,
    S_CAL1, S_CAL2, S_RET1, S_RET2, S_UN, S_BIN1, S_BIN2, S_DIV, S_TOP, S_FIN
  } pcsm_state_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [3:0]         level;
    logic [15:0]        operand;
    logic signed [31:0] read_value;
  } pcsm_in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halted;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic [1:0]         fault;
  } pcsm_out_t;

  typedef struct packed {
    logic start;
    logic want_rem;
  } pcsm_div_req_t;

  function automatic logic signed [EW-1:0] ext_idx(input logic [AW-1:0] x);
    return $signed({{(EW-AW){1'b0}}, x});
  endfunction

  function automatic logic signed [EW-1:0] ext_16(input logic [15:0] x);
    return $signed({{(EW-16){1'b0}}, x});
  endfunction

  function automatic logic in_rng(input logic signed [EW-1:0] v);
    return !v[EW-1] && (v < DEPTH_E);
  endfunction

  function automatic logic in_rng32(input logic [31:0] w);
    return !w[31] && ({1'b0, w} < DEPTH_33);
  endfunction

endpackage

`default_nettype wire

FILE: sv/pcode_stack_machine_core.sv
// ----------------------------------------------------------------------------
// pcode_stack_machine_core
// PL/0-style p-code stack machine executing one instruction per transaction.
// ----------------------------------------------------------------------------
// One instruction in flight; load, store and call first walk the static links one
//   level at a time, and a divide/modulo by a nonzero value waits on the iterative
//   divider. The next instruction can be accepted in the same cycle as the previous
//   result registers.
// Reset: synchronous active-low; a clearing pass then zeroes all STACK_DEPTH
//   stack words, one per cycle, with in_ready held low.
`default_nettype none

module pcode_stack_machine_core
  import pcsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pcsm_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pcsm_out_t      out_data
);

  pcsm_state_t state_r, state_nxt;

  // architectural state
  logic [AW-1:0] t_r, t_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic [15:0]   pc_r, pc_nxt;

  // instruction held for the duration of the transaction
  logic [3:0]  op_r, op_nxt;
  logic [3:0]  lev_r, lev_nxt;
  logic [15:0] a_r, a_nxt;
  logic [31:0] rv_r, rv_nxt;

  // working state
  logic [AW-1:0] nt_r, nt_nxt;
  logic [AW-1:0] nb_r, nb_nxt;
  logic [15:0]   np_r, np_nxt;
  logic [1:0]    fault_r, fault_nxt;
  logic          pvalid_r, pvalid_nxt;
  logic [31:0]   pval_r, pval_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [31:0]   y_r, y_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic      out_valid_r, out_valid_nxt;
  pcsm_out_t out_data_r, out_data_nxt;

  // stack RAM port
  logic          we_c;
  logic [AW-1:0] waddr_c;
  logic [31:0]   wdata_c;
  logic [AW-1:0] raddr_c;
  logic [31:0]   rdata;

  pcsm_div_req_t div_req_c;
  logic          div_done;
  logic [31:0]   div_result;

  pcsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  pcsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_c),
    .dividend (rdata),
    .divisor  (y_r),
    .done     (div_done),
    .result   (div_result)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic signed [EW-1:0] te, t_p1, t_m1, t_p3, t_pa, b_m1, b_p1, b_p2, p_pa;
    logic [31:0] x, y, bin;
    logic        out_free;
    logic        rng_fault;
    logic [15:0] pc_inc;

    te   = ext_idx(t_r);
    t_p1 = te + E1;
    t_m1 = te - E1;
    t_p3 = te + LINK_WORDS;
    t_pa = te + ext_16(a_r);
    b_m1 = ext_idx(b_r) - E1;
    b_p1 = ext_idx(b_r) + E1;
    b_p2 = ext_idx(b_r) + E2;
    p_pa = ext_idx(ptr_r) + ext_16(a_r);
    x    = rdata;
    y    = y_r;
    bin  = x;
    out_free  = !out_valid_r || out_ready;
    rng_fault = (fault_r == F_RANGE);
    pc_inc    = pc_r + 16'd1;

    state_nxt     = state_r;
    t_nxt         = t_r;
    b_nxt         = b_r;
    pc_nxt        = pc_r;
    op_nxt        = op_r;
    lev_nxt       = lev_r;
    a_nxt         = a_r;
    rv_nxt        = rv_r;
    nt_nxt        = nt_r;
    nb_nxt        = nb_r;
    np_nxt        = np_r;
    fault_nxt     = fault_r;
    pvalid_nxt    = pvalid_r;
    pval_nxt      = pval_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    y_nxt         = y_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    we_c          = 1'b0;
    waddr_c       = '0;
    wdata_c       = '0;
    raddr_c       = '0;
    div_req_c     = '0;

    case (state_r)
      S_CLEAR: begin
        // sweep zeroes through the whole stack
        we_c    = 1'b1;
        waddr_c = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.opcode;
          lev_nxt    = in_data.level;
          a_nxt      = in_data.operand;
          rv_nxt     = in_data.read_value;
          nt_nxt     = t_r;
          nb_nxt     = b_r;
          np_nxt     = pc_inc;
          fault_nxt  = F_NONE;
          pvalid_nxt = 1'b0;
          pval_nxt   = '0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_LIT, OP_IN: begin
            if (!in_rng(t_p1)) begin
              fault_nxt = F_RANGE;
            end else begin
              we_c    = 1'b1;
              waddr_c = t_p1[AW-1:0];
              wdata_c = (op_r == OP_LIT) ? {16'd0, a_r} : rv_r;
              nt_nxt  = t_p1[AW-1:0];
            end
          end
          OP_OPR: begin
            if (a_r == OPR_RET) begin
              if (!in_rng(b_m1) || !in_rng(b_p2)) begin
                fault_nxt = F_RANGE;
              end else begin
                raddr_c   = b_p1[AW-1:0];
                state_nxt = S_RET1;
              end
            end else if (a_r == OPR_NEG || a_r == OPR_ODD || a_r == OPR_NOT) begin
              if (!in_rng(te)) begin
                fault_nxt = F_RANGE;
              end else begin
                raddr_c   = t_r;
                state_nxt = S_UN;
              end
            end else if (a_r <= OPR_SHF) begin
              if (!in_rng(t_m1)) begin
                fault_nxt = F_RANGE;
              end else begin
                raddr_c   = t_r;
                state_nxt = S_BIN1;
              end
            end
          end
          OP_LOD, OP_STO, OP_CAL: begin
            ptr_nxt   = b_r;
            cnt_nxt   = lev_r;
            state_nxt = S_WALK;
          end
          OP_INI: begin
            if (!in_rng(t_pa)) begin
              fault_nxt = F_RANGE;
            end else begin
              nt_nxt = t_pa[AW-1:0];
            end
          end
          OP_JMP: begin
            np_nxt = a_r;
          end
          OP_JNE, OP_JEQ, OP_OUT: begin
            if (!in_rng(t_m1)) begin
              fault_nxt = F_RANGE;
            end else begin
              raddr_c   = t_r;
              state_nxt = S_TOP;
            end
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        // follow the static link one frame per round
        if (cnt_r == 4'd0) begin
          state_nxt = S_LINK;
        end else begin
          raddr_c   = ptr_r;
          state_nxt = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        if (!in_rng32(rdata)) begin
          fault_nxt = F_RANGE;
          state_nxt = S_FIN;
        end else begin
          ptr_nxt   = rdata[AW-1:0];
          cnt_nxt   = cnt_r - 4'd1;
          state_nxt = S_WALK;
        end
      end

      S_LINK: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_LOD: begin
            if (!in_rng(p_pa) || !in_rng(t_p1)) begin
              fault_nxt = F_RANGE;
            end else begin
              raddr_c   = p_pa[AW-1:0];
              state_nxt = S_LOD;
            end
          end
          OP_STO: begin
            if (!in_rng(p_pa) || !in_rng(t_m1)) begin
              fault_nxt = F_RANGE;
            end else begin
              raddr_c   = t_r;
              state_nxt = S_STO;
            end
          end
          default: begin
            // call: link words go above the current top
            if (!in_rng(t_p3)) begin
              fault_nxt = F_RANGE;
            end else begin
              we_c      = 1'b1;
              waddr_c   = t_p1[AW-1:0];
              wdata_c   = {{(32-AW){1'b0}}, ptr_r};
              state_nxt = S_CAL1;
            end
          end
        endcase
      end

      S_LOD: begin
        we_c      = 1'b1;
        waddr_c   = t_p1[AW-1:0];
        wdata_c   = rdata;
        nt_nxt    = t_p1[AW-1:0];
        state_nxt = S_FIN;
      end

      S_STO: begin
        we_c      = 1'b1;
        waddr_c   = p_pa[AW-1:0];
        wdata_c   = rdata;
        nt_nxt    = t_m1[AW-1:0];
        state_nxt = S_FIN;
      end

      S_CAL1: begin
        we_c      = 1'b1;
        waddr_c   = AW'(t_r + AW'(2));
        wdata_c   = {{(32-AW){1'b0}}, b_r};
        state_nxt = S_CAL2;
      end

      S_CAL2: begin
        we_c      = 1'b1;
        waddr_c   = t_p3[AW-1:0];
        wdata_c   = {16'd0, pc_inc};
        nb_nxt    = t_p1[AW-1:0];
        np_nxt    = a_r;
        state_nxt = S_FIN;
      end

      S_RET1: begin
        if (!in_rng32(rdata)) begin
          fault_nxt = F_RANGE;
          state_nxt = S_FIN;
        end else begin
          nb_nxt    = rdata[AW-1:0];
          raddr_c   = b_p2[AW-1:0];
          state_nxt = S_RET2;
        end
      end

      S_RET2: begin
        np_nxt    = rdata[15:0];
        nt_nxt    = b_m1[AW-1:0];
        state_nxt = S_FIN;
      end

      S_UN: begin
        we_c    = 1'b1;
        waddr_c = t_r;
        case (a_r)
          OPR_NEG: wdata_c = 32'd0 - x;
          OPR_ODD: wdata_c = {31'd0, x[0]};
          default: wdata_c = ~x;
        endcase
        state_nxt = S_FIN;
      end

      S_BIN1: begin
        y_nxt     = rdata;
        raddr_c   = t_m1[AW-1:0];
        state_nxt = S_BIN2;
      end

      S_BIN2: begin
        // x is the second entry, y the top
        case (a_r)
          OPR_ADD: bin = x + y;
          OPR_SUB: bin = x - y;
          OPR_MUL: bin = x * y;
          OPR_DIV: begin
            if (lev_r > 4'd1) begin
              bin = x;
            end else if (y == 32'd0) begin
              bin       = '0;
              fault_nxt = F_DIV0;
            end
          end
          OPR_EQ: begin
            if (lev_r == 4'd0) bin = {31'd0, x == y};
            else if (lev_r == 4'd1) bin = {31'd0, x != y};
          end
          OPR_LT: begin
            if (lev_r == 4'd0) bin = {31'd0, $signed(x) < $signed(y)};
            else if (lev_r == 4'd1) bin = {31'd0, $signed(x) <= $signed(y)};
          end
          OPR_GT: begin
            if (lev_r == 4'd0) bin = {31'd0, $signed(x) > $signed(y)};
            else if (lev_r == 4'd1) bin = {31'd0, $signed(x) >= $signed(y)};
          end
          OPR_AND:  bin = x & y;
          OPR_OR:   bin = x | y;
          OPR_XOR:  bin = x ^ y;
          OPR_LAND: bin = {31'd0, (x != 32'd0) && (y != 32'd0)};
          OPR_LOR:  bin = {31'd0, (x != 32'd0) || (y != 32'd0)};
          OPR_SHF: begin
            if (lev_r == 4'd0) begin
              bin = (|y[31:5]) ? 32'd0 : (x << y[4:0]);
            end else if (lev_r == 4'd1) begin
              bin = (|y[31:5]) ? {32{x[31]}} : 32'($signed(x) >>> y[4:0]);
            end
          end
          default: bin = x;
        endcase
        nt_nxt = t_m1[AW-1:0];
        if (a_r == OPR_DIV && lev_r <= 4'd1 && y != 32'd0) begin
          div_req_c.start    = 1'b1;
          div_req_c.want_rem = lev_r[0];
          state_nxt          = S_DIV;
        end else begin
          we_c      = 1'b1;
          waddr_c   = t_m1[AW-1:0];
          wdata_c   = bin;
          state_nxt = S_FIN;
        end
      end

      S_DIV: begin
        if (div_done) begin
          we_c      = 1'b1;
          waddr_c   = nt_r;
          wdata_c   = div_result;
          state_nxt = S_FIN;
        end
      end

      S_TOP: begin
        if (op_r == OP_OUT) begin
          pvalid_nxt = 1'b1;
          pval_nxt   = rdata;
        end else if ((op_r == OP_JNE) == (rdata == 32'd0)) begin
          np_nxt = a_r;
        end
        nt_nxt    = t_m1[AW-1:0];
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // commit once the result register is free; a range fault keeps b, zeroes t, steps pc on
        if (out_free) begin
          t_nxt  = rng_fault ? '0 : nt_r;
          b_nxt  = rng_fault ? b_r : nb_r;
          pc_nxt = rng_fault ? pc_inc : np_r;
          out_data_nxt.next_pc     = pc_nxt;
          out_data_nxt.halted      = (pc_nxt == 16'd0);
          out_data_nxt.print_valid = pvalid_r && !rng_fault;
          out_data_nxt.print_value = rng_fault ? 32'd0 : pval_r;
          out_data_nxt.fault       = fault_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      t_r         <= '0;
      b_r         <= AW'(1);
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      t_r         <= t_nxt;
      b_r         <= b_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    lev_r      <= lev_nxt;
    a_r        <= a_nxt;
    rv_r       <= rv_nxt;
    nt_r       <= nt_nxt;
    nb_r       <= nb_nxt;
    np_r       <= np_nxt;
    fault_r    <= fault_nxt;
    pvalid_r   <= pvalid_nxt;
    pval_r     <= pval_nxt;
    ptr_r      <= ptr_nxt;
    cnt_r      <= cnt_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/pcsm_ram.sv
// ----------------------------------------------------------------------------
// pcsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/pcsm_div.sv
// ----------------------------------------------------------------------------
// pcsm_div
// Signed 32-bit iterative divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_div
  import pcsm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pcsm_div_req_t req,
  input  wire logic [31:0]   dividend,
  input  wire logic [31:0]   divisor,
  output logic               done,
  output logic [31:0]        result
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] ub_r;
  logic        negq_r;
  logic        negr_r;
  logic        sel_rem_r;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic [31:0] q_fix;
  logic [31:0] r_fix;

  assign shifted = {rem_r[31:0], quo_r[31]};
  assign diff    = shifted - {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        rem_r     <= '0;
        quo_r     <= dividend[31] ? (32'd0 - dividend) : dividend;
        ub_r      <= divisor[31] ? (32'd0 - divisor) : divisor;
        negq_r    <= dividend[31] ^ divisor[31];
        negr_r    <= dividend[31];
        sel_rem_r <= req.want_rem;
      end else if (busy_r) begin
        if (!diff[32]) begin
          rem_r <= diff;
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q_fix  = negq_r ? (32'd0 - quo_r) : quo_r;
  assign r_fix  = negr_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];
  assign result = sel_rem_r ? r_fix : q_fix;
  assign done   = done_r;

endmodule

`default_nettype wire

FILE: sv/pcsm_checker.sv
// ----------------------------------------------------------------------------
// pcsm_checker
// Port-level checks for the p-code stack machine core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_checker
  import pcsm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire pcsm_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire pcsm_out_t out_data
);

  logic [3:0] in_op;
  assign in_op = in_data.opcode;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == in_op) |=> !in_ready)
    else $error("input accepted while an instruction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_halt_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.halted == (out_data.next_pc == 16'd0))
    else $error("halt mark disagrees with next pc");

  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.print_valid |-> out_data.print_value == 32'd0)
    else $error("print value set without print valid");

  a_fault_no_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault == F_RANGE |-> !out_data.print_valid)
    else $error("range fault with a printed value");

endmodule

bind pcode_stack_machine_core pcsm_checker u_pcsm_checker (.*);

`default_nettype wire
